// ----- src/pse_pkg.sv -----
`timescale 1ns / 1ps
package pse_pkg;
   localparam int STACK_DEPTH = 64;
   localparam int PTR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   localparam logic [7:0] SYM_XOR  = 8'h5E;
   localparam logic [7:0] SYM_MUL  = 8'h2A;
   localparam logic [7:0] SYM_DIV  = 8'h2F;
   localparam logic [7:0] SYM_ADD  = 8'h2B;
   localparam logic [7:0] SYM_SUB  = 8'h2D;
   localparam logic [7:0] SYM_ZERO = 8'h30;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNDERFLOW = 3'd1;
   localparam logic [2:0] ST_DIVZERO   = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_EMPTY_END = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture input word (symbol and last flag)
      logic exec;      // operands are valid: compute or start divide
      logic finish;    // write back result and form response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_busy;
   } sts_type;
endpackage

// ----- src/pse_divider.sv -----
`timescale 1ns / 1ps
module pse_divider
   import pse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in;
   logic [32:0] trial;
   logic [31:0] shifted;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; neg_in = neg_ff; busy_in = busy_ff;
      shifted = {rem_ff[30:0], quo_ff[31]};
      trial = {1'b0, shifted} - {1'b0, den_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend[31] ? 32'(0 - dividend) : dividend;
         den_in = divisor[31] ? 32'(0 - divisor) : divisor;
         neg_in = dividend[31] ^ divisor[31];
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // One restoring step per cycle.
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign busy = busy_ff;
   assign quotient = neg_ff ? 32'(0 - quo_ff) : quo_ff;
endmodule

// ----- src/pse_datapath.sv -----
`timescale 1ns / 1ps
module pse_datapath
   import pse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [7:0]  req_symbol,
   input  logic        req_last_symbol,
   output logic [31:0] res_top,
   output logic        res_done,
   output logic [2:0]  res_status
);
   logic [31:0] mem [STACK_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]  sym_ff;
   logic        last_ff, is_op, is_div;
   logic [31:0] rd_b_ff, rd_a_ff, prod_ff, alu_ff, alu_val;
   logic [31:0] top_ff, quot;
   logic [2:0]  status_ff;
   logic        done_ff, div_start, div_busy;
   logic [PTR_W-1:0] ptr_b, ptr_a;
   logic [31:0] result;
   logic [2:0]  st;
   logic        wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic [31:0] wr_data;
   logic [CNT_W-1:0] cnt_next;

   assign is_op = (sym_ff == SYM_XOR) || (sym_ff == SYM_MUL) || (sym_ff == SYM_DIV)
               || (sym_ff == SYM_ADD) || (sym_ff == SYM_SUB);
   assign is_div = sym_ff == SYM_DIV;
   assign ptr_b = PTR_W'(cnt_ff - CNT_W'(1));
   assign ptr_a = PTR_W'(cnt_ff - CNT_W'(2));

   // Registered reads of the two top entries.
   always_ff @(posedge clock) begin
      rd_b_ff <= mem[ptr_b];
      rd_a_ff <= mem[ptr_a];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   assign div_start = cmd.exec && is_op && is_div && (cnt_ff >= CNT_W'(2))
                   && (rd_b_ff != 32'd0);
   pse_divider u_div (
      .clock, .reset, .start(div_start), .dividend(rd_a_ff), .divisor(rd_b_ff),
      .busy(div_busy), .quotient(quot)
   );
   assign sts.div_busy = div_busy;

   always_comb begin
      case (sym_ff)
         SYM_XOR: alu_val = rd_a_ff ^ rd_b_ff;
         SYM_ADD: alu_val = rd_a_ff + rd_b_ff;
         SYM_SUB: alu_val = rd_a_ff - rd_b_ff;
         default: alu_val = 32'd0;
      endcase
   end

   always_comb begin
      st = ST_OK; wr_en = 1'b0; wr_addr = ptr_a; wr_data = 32'd0;
      cnt_next = cnt_ff; result = 32'd0;
      if (is_op) begin
         if (cnt_ff < CNT_W'(2)) st = ST_UNDERFLOW;
         else begin
            if (is_div) begin
               if (rd_b_ff == 32'd0) st = ST_DIVZERO;
               else result = quot;
            end else if (sym_ff == SYM_MUL) result = prod_ff;
            else result = alu_ff;
            wr_en = 1'b1; wr_addr = ptr_a; wr_data = result;
            cnt_next = cnt_ff - CNT_W'(1);
         end
      end else begin
         if (cnt_ff >= CNT_W'(STACK_DEPTH)) st = ST_FULL;
         else begin
            wr_en = 1'b1; wr_addr = PTR_W'(cnt_ff);
            wr_data = 32'(sym_ff) - 32'(SYM_ZERO);
            cnt_next = cnt_ff + CNT_W'(1);
         end
      end
      wr_en = wr_en && cmd.finish;
      cnt_in = cnt_ff;
      if (cmd.finish) cnt_in = last_ff ? '0 : cnt_next;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      if (cmd.load) begin
         sym_ff <= req_symbol;
         last_ff <= req_last_symbol;
      end
      if (cmd.exec) begin
         prod_ff <= rd_a_ff * rd_b_ff;
         alu_ff <= alu_val;
      end
      if (cmd.finish) begin
         done_ff <= last_ff;
         if (last_ff && st == ST_OK && cnt_next == '0) status_ff <= ST_EMPTY_END;
         else status_ff <= st;
         if (cnt_next == '0) top_ff <= 32'd0;
         else if (wr_en) top_ff <= wr_data;
         else top_ff <= rd_b_ff;
      end
   end

   assign res_top = top_ff;
   assign res_done = done_ff;
   assign res_status = status_ff;
endmodule

// ----- src/pse_controller.sv -----
`timescale 1ns / 1ps
module pse_controller
   import pse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);
   localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_EXEC = 3'd2,
                          S_WAIT = 3'd3, S_FIN = 3'd4;
   logic [2:0] state_ff, state_in;
   logic       vld_ff, vld_in;
   logic       take;

   // A new word enters only once the response register is free or drains now.
   assign req_stall = !(state_ff == S_IDLE) || (vld_ff && rsp_stall);
   assign take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.load = take;
      vld_in = vld_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: if (take) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: if (!sts.div_busy) state_in = S_FIN;
         S_FIN: begin
            if (!(vld_ff && rsp_stall)) begin
               cmd.finish = 1'b1;
               vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff;

   a_fin_from_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |-> $past(state_ff) == S_WAIT || $past(state_ff) == S_FIN)
      else $error("finish not preceded by wait");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !take) else $error("word taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff && rsp_stall |=> vld_ff) else $error("response dropped");
endmodule

// ----- src/postfix_stack_evaluator_unit.sv -----
`timescale 1ns / 1ps
// Postfix expression evaluator with a 64-entry operand stack.
// Input words arrive on req_ (symbol, last_symbol) with req_valid/req_stall;
// a word is taken on an edge with req_valid high and req_stall low.
// Each input word produces exactly one response word on rsp_ (top_value,
// expression_done, status) with rsp_valid/rsp_stall.
// After acceptance a word passes through the registered stack read, the
// compute step, a check of the divider, and the write back that raises
// rsp_valid. A division also waits for the restoring divider, which retires
// one quotient bit per cycle.
// One word is in flight at a time; the next word can be taken in the cycle
// the response appears, unless the receiver stalls that response.
// Reset clears the stack count and the controller; stack contents need no
// clearing because only entries below the count are ever used.
// When the receiver stalls, the response register holds its word and the
// next input word is not taken until that response is accepted.
module postfix_stack_evaluator_unit
   import pse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_symbol,
   input  logic        req_last_symbol,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_top_value,
   output logic        rsp_expression_done,
   output logic [2:0]  rsp_status
);
   cmd_type cmd;
   sts_type sts;
   logic [31:0] top;

   pse_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd, .sts
   );

   pse_datapath u_dp (
      .clock, .reset, .cmd, .sts, .req_symbol, .req_last_symbol,
      .res_top(top), .res_done(rsp_expression_done), .res_status(rsp_status)
   );

   assign rsp_top_value = signed'(top);
endmodule
